### src/gpuhf_pkg.sv
package gpuhf_pkg;

  localparam int unsigned FRAC_BITS   = 4;
  localparam int unsigned COORD_W     = 18;
  localparam int unsigned GRAY_W      = 13;
  localparam int unsigned GRAY_MAG_W  = GRAY_W - 1;
  localparam int unsigned PHASE_W     = 16;
  localparam int unsigned CFG_W       = 12;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned ROW_W       = 11;
  localparam int unsigned COL_W       = 11;
  localparam int unsigned LINE_DEPTH  = 2048;
  localparam int unsigned LINE_AW     = $clog2(LINE_DEPTH);
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 64;
  localparam int unsigned DIV_CNT_W   = $clog2(GRAY_MAG_W + 1);

  localparam logic [CFG_W-1:0] DIM_MIN = 12'd3;
  localparam logic [CFG_W-1:0] DIM_MAX = 12'd2048;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH   = 12'd1280;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT  = 12'd1024;
  localparam logic [CFG_W-1:0] RST_X_PERIOD      = 12'd20;
  localparam logic [CFG_W-1:0] RST_X_GRAY_PERIOD = 12'd10;
  localparam logic [CFG_W-1:0] RST_Y_PERIOD      = 12'd20;
  localparam logic [CFG_W-1:0] RST_Y_GRAY_PERIOD = 12'd10;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_X_PERIOD      = 3'd2,
    REG_X_GRAY_PERIOD = 3'd3,
    REG_Y_PERIOD      = 3'd4,
    REG_Y_GRAY_PERIOD = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_WAIT
  } state_e;

  typedef struct packed {
    coord_t             proj_x;
    coord_t             proj_y;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic               last;
  } res_t;

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    if (v < DIM_MIN) r = DIM_MIN;
    else if (v > DIM_MAX) r = DIM_MAX;
    else r = v;
    return r;
  endfunction

  function automatic logic is_pos(input coord_t v);
    return !v[COORD_W-1] && (v != '0);
  endfunction

endpackage

### src/gpuhf_ram.sv
module gpuhf_ram #(
  parameter int unsigned DATA_W = 18,
  parameter int unsigned ADDR_W = 11
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/gpuhf_unwrap.sv
module gpuhf_unwrap import gpuhf_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [GRAY_W-1:0]  gray_i,
  input  logic [PHASE_W-1:0]        phase_i,
  input  logic [CFG_W-1:0]          period_i,
  input  logic [CFG_W-1:0]          gray_period_i,
  output logic                      done_o,
  output coord_t                    coord_o
);

  logic signed [GRAY_W-1:0] gray_q;
  logic [PHASE_W-1:0]       phase_q;
  logic [CFG_W-1:0]         period_q;
  logic [CFG_W-1:0]         dvs_q;
  logic [GRAY_MAG_W-1:0]    dvd_q, dvd_d;
  logic [GRAY_MAG_W:0]      rem_q, rem_d;
  logic                     qbit_q, qbit_d;
  logic [DIV_CNT_W-1:0]     cnt_q;
  logic                     busy_q, done_q;

  logic [GRAY_MAG_W:0]      rem_sh;
  logic                     ge;

  // one quotient bit per cycle, only the parity of the final quotient is kept
  always_comb begin
    rem_sh = {rem_q[GRAY_MAG_W-1:0], dvd_q[GRAY_MAG_W-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_d  = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
    dvd_d  = {dvd_q[GRAY_MAG_W-2:0], 1'b0};
    qbit_d = ge;
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      gray_q   <= gray_i;
      phase_q  <= phase_i;
      period_q <= period_i;
      dvs_q    <= (gray_period_i == '0) ? CFG_W'(1) : gray_period_i;
      dvd_q    <= gray_i[GRAY_MAG_W-1:0];
      rem_q    <= '0;
      qbit_q   <= 1'b0;
    end else if (busy_q) begin
      dvd_q  <= dvd_d;
      rem_q  <= rem_d;
      qbit_q <= qbit_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= DIV_CNT_W'(GRAY_MAG_W);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  logic [PHASE_W-1:0]  pfx;
  logic [PHASE_W+1:0]  ph4, p3;
  logic signed [PHASE_W+2:0] phs;
  logic signed [PHASE_W+3:0] sum;

  always_comb begin
    pfx = {period_q, {FRAC_BITS{1'b0}}};
    ph4 = {phase_q, 2'b00};
    p3  = {2'b00, pfx} + {1'b0, pfx, 1'b0};
    phs = signed'({3'b000, phase_q});
    if (!qbit_q) begin
      if (ph4 > p3) phs = phs - signed'({3'b000, pfx});
    end else begin
      if (ph4 < {2'b00, pfx}) phs = phs + signed'({3'b000, pfx});
      phs = phs - signed'({4'b0000, pfx[PHASE_W-1:1]});
    end
    sum = signed'({4'b0000, gray_q[GRAY_MAG_W-1:0], {FRAC_BITS{1'b0}}}) +
          signed'({phs[PHASE_W+2], phs});
    if (gray_q[GRAY_W-1]) begin
      coord_o = {gray_q[GRAY_W-1], gray_q, {FRAC_BITS{1'b0}}};
    end else if (sum > 20'sd131071) begin
      coord_o = 18'sh1FFFF;
    end else if (sum < -20'sd131072) begin
      coord_o = 18'sh20000;
    end else begin
      coord_o = sum[COORD_W-1:0];
    end
  end

  assign done_o = done_q;

endmodule

### src/gray_phase_unwrap_hole_fill.sv
// One pixel is in work at a time: a new pixel is taken only after the current one is written
// back, which waits for the bit-serial Gray stripe divider (12 steps), the line memory
//   reads and an empty output buffer.
// Results go through a two-word output buffer; the next pixel is taken while it drains.
// Reset: asynchronous, active low; clears counters, left neighbor, buffer and
//   registers to defaults. Line memories are not cleared.
module gray_phase_unwrap_hole_fill import gpuhf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // gray_x[12:0], phase_x[28:13], gray_y[41:29], phase_y[57:42], zero fill
  input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // proj_x[17:0], proj_y[35:18], out_row[46:36], out_col[57:47], zero fill
  output logic [OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                    m_axis_tlast,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [CFG_W-1:0]        cfg_data_i
);

  logic [CFG_W-1:0] frame_w_q, frame_h_q, x_per_q, x_gper_q, y_per_q, y_gper_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_w_q <= RST_FRAME_WIDTH;
      frame_h_q <= RST_FRAME_HEIGHT;
      x_per_q   <= RST_X_PERIOD;
      x_gper_q  <= RST_X_GRAY_PERIOD;
      y_per_q   <= RST_Y_PERIOD;
      y_gper_q  <= RST_Y_GRAY_PERIOD;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_FRAME_WIDTH:   frame_w_q <= cfg_data_i;
        REG_FRAME_HEIGHT:  frame_h_q <= cfg_data_i;
        REG_X_PERIOD:      x_per_q   <= cfg_data_i;
        REG_X_GRAY_PERIOD: x_gper_q  <= cfg_data_i;
        REG_Y_PERIOD:      y_per_q   <= cfg_data_i;
        REG_Y_GRAY_PERIOD: y_gper_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  state_e           state_q, state_d;
  logic             accept, start, commit;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  coord_t           y_left_q, y_left_d;
  coord_t           ox_q, oy_q, up_q, rt_q;
  res_t             slot0_q, slot0_d, slot1_q, slot1_d;
  logic [1:0]       out_cnt_q, out_cnt_d;
  logic             x_done, y_done;
  coord_t           nx, ny;

  assign accept = s_axis_tvalid && s_axis_tready;

  gpuhf_unwrap u_unwrap_x (
    .clk_i,
    .rst_ni,
    .start_i       (start),
    .gray_i        (s_axis_tdata[12:0]),
    .phase_i       (s_axis_tdata[28:13]),
    .period_i      (x_per_q),
    .gray_period_i (x_gper_q),
    .done_o        (x_done),
    .coord_o       (nx)
  );

  gpuhf_unwrap u_unwrap_y (
    .clk_i,
    .rst_ni,
    .start_i       (start),
    .gray_i        (s_axis_tdata[41:29]),
    .phase_i       (s_axis_tdata[57:42]),
    .period_i      (y_per_q),
    .gray_period_i (y_gper_q),
    .done_o        (y_done),
    .coord_o       (ny)
  );

  // raw line holds {x, y} of the previous row, filled line holds filled x
  logic [LINE_AW-1:0]     raw_raddr;
  logic [2*COORD_W-1:0]   raw_rdata;
  coord_t                 filled_rdata;
  coord_t                 ox_fill, oy_fill;
  logic                   row_nz;

  assign raw_raddr = (state_q == S_RD1) ? col_q + COL_W'(1) : col_q;
  assign row_nz    = row_q != '0;

  gpuhf_ram #(.DATA_W(2*COORD_W), .ADDR_W(LINE_AW)) u_raw_line (
    .clk_i,
    .we_i    (commit),
    .waddr_i (col_q),
    .wdata_i ({nx, ny}),
    .raddr_i (raw_raddr),
    .rdata_o (raw_rdata)
  );

  gpuhf_ram #(.DATA_W(COORD_W), .ADDR_W(LINE_AW)) u_filled_line (
    .clk_i,
    .we_i    (commit && row_nz),
    .waddr_i (col_q),
    .wdata_i (ox_fill),
    .raddr_i (col_q),
    .rdata_o (filled_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (s_axis_tvalid) state_d = S_RD1;
      S_RD1:  state_d = S_RD2;
      S_RD2:  state_d = S_WAIT;
      S_WAIT: if (x_done && y_done && out_cnt_q == '0) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    start         = 1'b0;
    commit        = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        start         = s_axis_tvalid;
      end
      S_WAIT: commit = x_done && y_done && out_cnt_q == '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RD1) begin
      ox_q <= raw_rdata[2*COORD_W-1:COORD_W];
      oy_q <= raw_rdata[COORD_W-1:0];
      up_q <= filled_rdata;
    end
    if (state_q == S_RD2) begin
      rt_q <= raw_rdata[COORD_W-1:0];
    end
  end

  logic [CFG_W-1:0]   w, h, r12, c12;
  logic               interior, last_row, row_wrap;
  logic [COORD_W:0]   x_sum, y_sum;
  res_t               res_a, res_b;

  always_comb begin
    w        = clamp_dim(frame_w_q);
    h        = clamp_dim(frame_h_q);
    r12      = {1'b0, row_q};
    c12      = {1'b0, col_q};
    last_row = r12 + CFG_W'(1) >= h;
    row_wrap = c12 + CFG_W'(1) >= w;
    interior = (row_q >= ROW_W'(2)) && (r12 + CFG_W'(1) <= h) &&
               (col_q != '0) && (c12 + CFG_W'(2) <= w);

    // average of two positive neighbors, truncated
    x_sum   = {1'b0, up_q} + {1'b0, nx};
    y_sum   = {1'b0, y_left_q} + {1'b0, rt_q};
    ox_fill = ox_q;
    oy_fill = oy_q;
    if (interior && ox_q[COORD_W-1] && is_pos(up_q) && is_pos(nx)) begin
      ox_fill = x_sum[COORD_W:1];
    end
    if (interior && oy_q[COORD_W-1] && is_pos(y_left_q) && is_pos(rt_q)) begin
      oy_fill = y_sum[COORD_W:1];
    end

    res_a = '{proj_x: ox_fill, proj_y: oy_fill, row: row_q - ROW_W'(1), col: col_q,
              last: !last_row};
    res_b = '{proj_x: nx, proj_y: ny, row: row_q, col: col_q, last: 1'b1};

    col_d    = col_q;
    row_d    = row_q;
    y_left_d = y_left_q;
    if (commit) begin
      if (row_nz) y_left_d = oy_fill;
      if (row_wrap) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  // output buffer: slot0 drives the port, slot1 holds the second word
  always_comb begin
    slot0_d   = slot0_q;
    slot1_d   = slot1_q;
    out_cnt_d = out_cnt_q;
    if (commit) begin
      slot0_d   = row_nz ? res_a : res_b;
      slot1_d   = res_b;
      out_cnt_d = 2'(row_nz) + 2'(last_row);
    end else if (m_axis_tvalid && m_axis_tready) begin
      slot0_d   = slot1_q;
      out_cnt_d = out_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      row_q     <= '0;
      col_q     <= '0;
      y_left_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      row_q     <= row_d;
      col_q     <= col_d;
      y_left_q  <= y_left_d;
      out_cnt_q <= out_cnt_d;
    end
  end

  assign m_axis_tvalid = out_cnt_q != '0;
  assign m_axis_tlast  = slot0_q.last;
  assign m_axis_tdata  = {6'd0, slot0_q.col, slot0_q.row, slot0_q.proj_y, slot0_q.proj_x};

endmodule

### src/gpuhf_checker.sv
module gpuhf_checker import gpuhf_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast,
  input logic                   cfg_valid_i,
  input logic                   cfg_ready_o,
  input logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input logic [CFG_W-1:0]       cfg_data_i
);

  // a stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tlast))
  else $error("output word changed while stalled");

  // one pixel in flight: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
  else $error("input taken on two consecutive cycles");

  // the second word of a pixel is already buffered when the first leaves
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
  else $error("gap inside a result run");

  // nothing presented while in reset
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
  else $error("output valid during reset");

endmodule

bind gray_phase_unwrap_hole_fill gpuhf_checker u_checker (.*);

### sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gpuhf_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned LIMIT_CYCLES  = 1_000_000;
  localparam int          MAX_REPORTS   = 10;
  localparam longint      FX_ONE        = longint'(1) << FRAC_BITS;
  localparam longint      COORD_HI      = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint      COORD_LO      = -(longint'(1) << (COORD_W - 1));

  // gx lowest, phy highest: same order as the input word
  typedef struct packed {
    logic [PHASE_W-1:0] phy;
    logic [GRAY_W-1:0]  gy;
    logic [PHASE_W-1:0] phx;
    logic [GRAY_W-1:0]  gx;
  } pixel_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_ADDR_W-1:0]  cfg_addr_i    = '0;
  logic [CFG_W-1:0]       cfg_data_i    = '0;

  // shadow of the register file
  logic [CFG_W-1:0] frame_w  = RST_FRAME_WIDTH;
  logic [CFG_W-1:0] frame_h  = RST_FRAME_HEIGHT;
  logic [CFG_W-1:0] x_period = RST_X_PERIOD;
  logic [CFG_W-1:0] x_stripe = RST_X_GRAY_PERIOD;
  logic [CFG_W-1:0] y_period = RST_Y_PERIOD;
  logic [CFG_W-1:0] y_stripe = RST_Y_GRAY_PERIOD;

  // line stores and position of the unwrap/fill predictor
  coord_t      x_raw_line  [LINE_DEPTH];
  coord_t      x_fill_line [LINE_DEPTH];
  coord_t      y_raw_line  [LINE_DEPTH];
  coord_t      y_left      = '0;
  int unsigned row_cnt     = 0;
  int unsigned col_cnt     = 0;

  res_t        proj_q[$];
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int          err_cnt        = 0;
  int unsigned cycle_cnt      = 0;

  gray_phase_unwrap_hole_fill i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic coord_t sat_coord(input longint v);
    if (v > COORD_HI) return coord_t'(COORD_HI);
    if (v < COORD_LO) return coord_t'(COORD_LO);
    return coord_t'(v);
  endfunction

  function automatic int unsigned dim_eff(input logic [CFG_W-1:0] v);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > DIM_MAX) return DIM_MAX;
    return v;
  endfunction

  function automatic coord_t unwrap_coord(input logic [GRAY_W-1:0] gray,
                                          input logic [PHASE_W-1:0] phase,
                                          input logic [CFG_W-1:0] period,
                                          input logic [CFG_W-1:0] stripe);
    longint g, ph, span, stripe_w;
    g    = longint'($signed(gray));
    ph   = longint'(phase);
    span = longint'(period) * FX_ONE;
    if (g < 0) return sat_coord(g * FX_ONE);
    stripe_w = (stripe == '0) ? 1 : longint'(stripe);
    if (((g / stripe_w) % 2) == 0) begin
      if (4 * ph > 3 * span) ph -= span;
    end else begin
      if (4 * ph < span) ph += span;
      ph -= span / 2;
    end
    return sat_coord(g * FX_ONE + ph);
  endfunction

  // Emit the pixel one row up (filled), and on the last row the pixel itself.
  function automatic void unwrap_fill(input pixel_t p);
    int unsigned w, h, r, c, n;
    coord_t      nx, ny, ox, oy;
    res_t        outs[2];
    w  = dim_eff(frame_w);
    h  = dim_eff(frame_h);
    r  = row_cnt;
    c  = (col_cnt < LINE_DEPTH) ? col_cnt : LINE_DEPTH - 1;
    nx = unwrap_coord(p.gx, p.phx, x_period, x_stripe);
    ny = unwrap_coord(p.gy, p.phy, y_period, y_stripe);
    n  = 0;
    if (r >= 1) begin
      ox = x_raw_line[c];
      oy = y_raw_line[c];
      if (r >= 2 && r + 1 <= h && c >= 1 && c + 2 <= w) begin
        if (ox < 0 && x_fill_line[c] > 0 && nx > 0)
          ox = coord_t'((longint'(x_fill_line[c]) + longint'(nx)) / 2);
        if (oy < 0 && y_left > 0 && y_raw_line[c+1] > 0)
          oy = coord_t'((longint'(y_left) + longint'(y_raw_line[c+1])) / 2);
      end
      outs[n] = '{proj_x: ox, proj_y: oy, row: ROW_W'(r - 1), col: COL_W'(c), last: 1'b0};
      n++;
      x_fill_line[c] = ox;
      y_left         = oy;
    end
    x_raw_line[c] = nx;
    y_raw_line[c] = ny;
    if (r + 1 >= h) begin
      outs[n] = '{proj_x: nx, proj_y: ny, row: ROW_W'(r), col: COL_W'(c), last: 1'b0};
      n++;
    end
    if (n > 0) outs[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) proj_q.push_back(outs[k]);
    if (col_cnt + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_cnt = col_cnt + 1;
    end
  endfunction

  function automatic logic [GRAY_W-1:0] rand_gray();
    int unsigned sel;
    sel = $urandom_range(19);
    if (sel < 2) return '1;
    if (sel == 2) return {1'b1, 12'($urandom)};
    if (sel == 3) return GRAY_W'(4095);
    return GRAY_W'($urandom_range(4095));
  endfunction

  function automatic logic [PHASE_W-1:0] rand_phase(input logic [CFG_W-1:0] period);
    longint span;
    span = longint'(period) * FX_ONE;
    if (span == 0 || $urandom_range(7) == 0) return PHASE_W'($urandom);
    return PHASE_W'($urandom_range(int'(span - 1)));
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p.gx  = rand_gray();
    p.phx = rand_phase(x_period);
    p.gy  = rand_gray();
    p.phy = rand_phase(y_period);
    return p;
  endfunction

  function automatic logic [CFG_W-1:0] rand_period();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return CFG_W'($urandom);
      default: return CFG_W'($urandom_range(1, 40));
    endcase
  endfunction

  task automatic send_pixel(input pixel_t p);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(p);
    do @(posedge clk_i); while (!s_axis_tready);
    unwrap_fill(p);
  endtask

  // Hold the input until every expected word is out, then let row 0 work settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (proj_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_FRAME_WIDTH:   frame_w  = val;
      REG_FRAME_HEIGHT:  frame_h  = val;
      REG_X_PERIOD:      x_period = val;
      REG_X_GRAY_PERIOD: x_stripe = val;
      REG_Y_PERIOD:      y_period = val;
      REG_Y_GRAY_PERIOD: y_stripe = val;
      default: ;
    endcase
  endtask

  // Reconfigure only at a frame boundary so no stale line entry is ever read.
  task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                           input logic [CFG_W-1:0] xp, input logic [CFG_W-1:0] xs,
                           input logic [CFG_W-1:0] yp, input logic [CFG_W-1:0] ys);
    drain();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_X_PERIOD, xp);
    write_reg(REG_X_GRAY_PERIOD, xs);
    write_reg(REG_Y_PERIOD, yp);
    write_reg(REG_Y_GRAY_PERIOD, ys);
    cfg_valid_i <= 1'b0;
  endtask

  // 3x3 frame: center is a hole on both axes with all neighbors positive.
  task automatic test_directed_fill();
    pixel_t p;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    configure(12'd3, 12'd3, 12'd20, 12'd10, 12'd20, 12'd10);
    for (int i = 0; i < 9; i++) begin
      // even stripe with phase past 3/4 period on x, odd stripe with low phase on y
      p = '{gx: 13'd25, phx: 16'd300, gy: 13'd15, phy: 16'd50};
      if (i == 0) begin
        p.gx  = 13'd4095;
        p.phx = '1;
        p.gy  = '0;
        p.phy = '0;
      end
      if (i == 4) begin
        p.gx  = '1;
        p.phx = '1;
        p.gy  = '1;
      end
      send_pixel(p);
    end
  endtask

  // Zero period and stripe on x, largest on y; blocked fills and chained holes.
  task automatic test_directed_special();
    pixel_t p;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    configure(12'd4, 12'd4, 12'd0, 12'd0, 12'd4095, 12'd4095);
    for (int i = 0; i < 16; i++) begin
      p.gx  = GRAY_W'(3 * i);
      p.phx = PHASE_W'(4000 * i);
      p.gy  = GRAY_W'(257 * i);
      p.phy = PHASE_W'(4369 * i);
      if (i == 5) p.gx = 13'h1000;
      if (i == 6) p.gx = '1;
      if (i == 10) begin
        p.gx  = '0;
        p.phx = '0;
      end
      if (i == 9 || i == 10) p.gy = '1;
      if (i == 8) drain();
      send_pixel(p);
    end
  endtask

  task automatic test_widest_frame();
    int unsigned n_pix;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    configure(12'hFFF, 12'd0, rand_period(), rand_period(), rand_period(), rand_period());
    n_pix = dim_eff(frame_w) * dim_eff(frame_h);
    for (int i = 0; i < n_pix; i++) send_pixel(rand_pixel());
  endtask

  task automatic test_random(input int unsigned src_pct, input int unsigned sink_pct,
                             input int unsigned n_items);
    int unsigned sent, n_pix;
    int          pause_at;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    sent           = 0;
    while (sent < n_items) begin
      configure(CFG_W'($urandom_range(12)), CFG_W'($urandom_range(8)), rand_period(),
                rand_period(), rand_period(), rand_period());
      n_pix    = dim_eff(frame_w) * dim_eff(frame_h);
      pause_at = ($urandom_range(5) == 0) ? int'($urandom_range(n_pix - 1)) : -1;
      for (int i = 0; i < n_pix; i++) begin
        if (i == pause_at) drain();
        send_pixel(rand_pixel());
      end
      sent += n_pix;
    end
  endtask

  // Height register beyond the largest frame height (clamped); only the first rows are run.
  task automatic test_tallest_frame();
    src_idle_pct   = 19;
    sink_stall_pct = 19;
    configure(12'd3, 12'hFFF, rand_period(), rand_period(), rand_period(), rand_period());
    for (int i = 0; i < 180; i++) send_pixel(rand_pixel());
  endtask

  always @(posedge clk_i) begin : sink
    res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.proj_x = m_axis_tdata[COORD_W-1:0];
      got.proj_y = m_axis_tdata[2*COORD_W-1:COORD_W];
      got.row    = m_axis_tdata[2*COORD_W +: ROW_W];
      got.col    = m_axis_tdata[2*COORD_W+ROW_W +: COL_W];
      got.last   = m_axis_tlast;
      if (proj_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("unexpected word: x=%0d y=%0d row=%0d col=%0d last=%0d",
                   got.proj_x, got.proj_y, got.row, got.col, got.last);
      end else begin
        want = proj_q.pop_front();
        if (got !== want) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("mismatch: want x=%0d y=%0d row=%0d col=%0d last=%0d, got x=%0d y=%0d row=%0d col=%0d last=%0d",
                     want.proj_x, want.proj_y, want.row, want.col, want.last,
                     got.proj_x, got.proj_y, got.row, got.col, got.last);
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_fill();
    test_directed_special();
    test_widest_frame();
    test_random(0, 0, 340);
    test_random(59, 0, 340);
    test_random(0, 59, 340);
    test_random(19, 19, 340);
    test_tallest_frame();
    drain();
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
src/gpuhf_pkg.sv
src/gpuhf_ram.sv
src/gpuhf_unwrap.sv
src/gray_phase_unwrap_hole_fill.sv
src/gpuhf_checker.sv
sim/tb_top.sv
